// File: rtl/md5_pkg.sv
// Shared types, constants and microcode program of the MD5 byte-stream digest.
`default_nettype none
package md5_pkg;

  localparam int unsigned STEP_W  = 4;
  localparam int unsigned COUNT_W = 61;

  typedef logic [STEP_W-1:0] step_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_LOAD,
    OP_ROUND,
    OP_ADD,
    OP_PAD,
    OP_LEN,
    OP_EMIT,
    OP_INIT
  } op_e;

  typedef enum logic [2:0] {
    C_NEXT,
    C_ALWAYS,
    C_HOLD,
    C_FIN,
    C_SHORT,
    C_MORE,
    C_EMIT
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic pos_last;
    logic short_msg;
    logic round_more;
    logic emit_last;
  } stat_t;

  localparam step_t S_WAIT   = 4'd0;
  localparam step_t S_BRANCH = 4'd1;
  localparam step_t S_LOAD0  = 4'd2;
  localparam step_t S_ROUND0 = 4'd3;
  localparam step_t S_ADD0   = 4'd4;
  localparam step_t S_PAD    = 4'd5;
  localparam step_t S_LOAD1  = 4'd6;
  localparam step_t S_ROUND1 = 4'd7;
  localparam step_t S_ADD1   = 4'd8;
  localparam step_t S_LEN    = 4'd9;
  localparam step_t S_LOAD2  = 4'd10;
  localparam step_t S_ROUND2 = 4'd11;
  localparam step_t S_ADD2   = 4'd12;
  localparam step_t S_EMIT   = 4'd13;
  localparam step_t S_INIT   = 4'd14;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  function automatic uword_t ucode(input step_t pc);
    uword_t w;
    w = '{op: OP_NOP, cond: C_ALWAYS, target: S_WAIT};
    case (pc)
      S_WAIT:   w = '{op: OP_ACCEPT, cond: C_HOLD,   target: S_WAIT};
      S_BRANCH: w = '{op: OP_NOP,    cond: C_FIN,    target: S_PAD};
      S_LOAD0:  w = '{op: OP_LOAD,   cond: C_NEXT,   target: S_WAIT};
      S_ROUND0: w = '{op: OP_ROUND,  cond: C_MORE,   target: S_ROUND0};
      S_ADD0:   w = '{op: OP_ADD,    cond: C_ALWAYS, target: S_WAIT};
      S_PAD:    w = '{op: OP_PAD,    cond: C_SHORT,  target: S_LOAD2};
      S_LOAD1:  w = '{op: OP_LOAD,   cond: C_NEXT,   target: S_WAIT};
      S_ROUND1: w = '{op: OP_ROUND,  cond: C_MORE,   target: S_ROUND1};
      S_ADD1:   w = '{op: OP_ADD,    cond: C_NEXT,   target: S_WAIT};
      S_LEN:    w = '{op: OP_LEN,    cond: C_NEXT,   target: S_WAIT};
      S_LOAD2:  w = '{op: OP_LOAD,   cond: C_NEXT,   target: S_WAIT};
      S_ROUND2: w = '{op: OP_ROUND,  cond: C_MORE,   target: S_ROUND2};
      S_ADD2:   w = '{op: OP_ADD,    cond: C_NEXT,   target: S_WAIT};
      S_EMIT:   w = '{op: OP_EMIT,   cond: C_EMIT,   target: S_EMIT};
      S_INIT:   w = '{op: OP_INIT,   cond: C_ALWAYS, target: S_WAIT};
      default:  w = '{op: OP_NOP,    cond: C_ALWAYS, target: S_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [31:0] k_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [3:0] sel);
    logic [4:0] s;
    case (sel)
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

endpackage
`default_nettype wire

// File: rtl/md5_byte_stream_digest.sv
// Top level of the MD5 byte-stream digest engine.
// Usage:
//   The slave stream takes one item per handshake. tuser[0] = 0 marks a
//   message byte in tdata[7:0]; tuser[0] = 1 finishes the message.
//   Each finish item produces four items on the master stream, the digest
//   words A, B, C, D in order, each with its first digest byte in bits 7:0;
//   tuser carries the word index and tlast marks word D.
//   Throughput: a byte item is taken every cycle, except that the byte that
//   completes a 64-byte block blocks the input while the
//   shared round unit runs one MD5 step per cycle (load, 64 rounds, add).
//   Finish: one padded block, or two when the length spills into a second
//   block, then one digest word per cycle while the master side is ready;
//   each word passes through the output register on its way out.
//   A microcode program sequences all of this; ready is high only on its
//   wait step.
//   The output register holds a word while the receiver stalls, and the
//   sequencer waits on it; after word D is loaded the engine returns to its
//   initial chaining value in an init step and then takes the next message.
//   Reset (rst_ni low) loads the initial chaining value, clears the byte
//   count and empties the output register.
`default_nettype none
module md5_byte_stream_digest (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_axis_tuser,   // [0] req_type
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
  output logic [1:0]       m_axis_tuser,   // [1:0] word_index
  output logic             m_axis_tlast    // last_word
);

  md5_pkg::op_e   op;
  md5_pkg::stat_t stat;
  logic           accept;

  assign s_axis_tready = (op == md5_pkg::OP_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;

  md5_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .req_type_i (s_axis_tuser[0]),
    .stat_i     (stat),
    .op_o       (op)
  );

  md5_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .accept_i      (accept),
    .req_type_i    (s_axis_tuser[0]),
    .data_byte_i   (s_axis_tdata),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .digest_word_o (m_axis_tdata),
    .word_index_o  (m_axis_tuser),
    .last_word_o   (m_axis_tlast),
    .stat_o        (stat)
  );

endmodule
`default_nettype wire

// File: rtl/md5_seq.sv
// Microcode sequencer: step counter, control ROM and conditional jumps.
`default_nettype none
module md5_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           accept_i,
  input  wire logic           req_type_i,
  input  wire md5_pkg::stat_t stat_i,
  output md5_pkg::op_e        op_o
);

  md5_pkg::step_t  pc_q, pc_d;
  md5_pkg::uword_t uw;
  logic            fin_q, fin_d;
  logic            take;

  assign uw   = md5_pkg::ucode(pc_q);
  assign op_o = uw.op;

  always_comb begin
    case (uw.cond)
      md5_pkg::C_NEXT:   take = 1'b0;
      md5_pkg::C_ALWAYS: take = 1'b1;
      md5_pkg::C_HOLD:   take = !accept_i || (!req_type_i && !stat_i.pos_last);
      md5_pkg::C_FIN:    take = fin_q;
      md5_pkg::C_SHORT:  take = stat_i.short_msg;
      md5_pkg::C_MORE:   take = stat_i.round_more;
      md5_pkg::C_EMIT:   take = !stat_i.emit_last;
      default:           take = 1'b0;
    endcase
  end

  always_comb begin
    pc_d  = take ? uw.target : pc_q + md5_pkg::step_t'(1);
    fin_d = accept_i ? req_type_i : fin_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q  <= md5_pkg::S_WAIT;
      fin_q <= 1'b0;
    end else begin
      pc_q  <= pc_d;
      fin_q <= fin_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (uw.op == md5_pkg::OP_INIT) |=> (pc_q == md5_pkg::S_WAIT))
    else $error("sequencer did not return to wait after init");

endmodule
`default_nettype wire

// File: rtl/md5_dp.sv
// Datapath: message buffer, byte counter, round unit, chaining value, output register.
`default_nettype none
module md5_dp (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire md5_pkg::op_e   op_i,
  input  wire logic           accept_i,
  input  wire logic           req_type_i,
  input  wire logic [7:0]     data_byte_i,
  input  wire logic           out_ready_i,
  output logic                out_valid_o,
  output logic [31:0]         digest_word_o,
  output logic [1:0]          word_index_o,
  output logic                last_word_o,
  output md5_pkg::stat_t      stat_o
);

  logic [3:0][7:0]              msg_q [16];
  logic [md5_pkg::COUNT_W-1:0]  count_q;
  logic [31:0]                  chain_q [4];
  logic [31:0]                  a_q, b_q, c_q, d_q;
  logic [5:0]                   round_q;
  logic [1:0]                   widx_q;
  logic                         ovalid_q;
  logic [31:0]                  odata_q;
  logic [1:0]                   oidx_q;
  logic                         olast_q;

  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [31:0] f, t, rot, b_d;
  logic [3:0]  g;
  logic [4:0]  s;
  logic        oload;

  assign pos     = count_q[5:0];
  assign bit_len = {count_q, 3'b000};
  assign oload   = (op_i == md5_pkg::OP_EMIT) && (!ovalid_q || out_ready_i);

  assign stat_o.pos_last   = (pos == 6'd63);
  assign stat_o.short_msg  = (pos < 6'd56);
  assign stat_o.round_more = (round_q != 6'd63);
  assign stat_o.emit_last  = oload && (widx_q == 2'd3);

  always_comb begin
    case (round_q[5:4])
      2'd0: begin
        f = d_q ^ (b_q & (c_q ^ d_q));
        g = round_q[3:0];
      end
      2'd1: begin
        f = c_q ^ (d_q & (b_q ^ c_q));
        g = 4'((round_q[3:0] << 2) + round_q[3:0] + 4'd1);
      end
      2'd2: begin
        f = b_q ^ c_q ^ d_q;
        g = 4'((round_q[3:0] << 1) + round_q[3:0] + 4'd5);
      end
      default: begin
        f = c_q ^ (b_q | ~d_q);
        g = 4'((round_q[3:0] << 3) - round_q[3:0]);
      end
    endcase
    s   = md5_pkg::rot_amt({round_q[5:4], round_q[1:0]});
    t   = a_q + f + msg_q[g] + md5_pkg::k_const(round_q);
    rot = (t << s) | (t >> (6'd32 - {1'b0, s}));
    b_d = b_q + rot;
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      md5_pkg::OP_ACCEPT: begin
        if (accept_i && !req_type_i) begin
          msg_q[pos[5:2]][pos[1:0]] <= data_byte_i;
        end
      end
      md5_pkg::OP_PAD: begin
        for (int w = 0; w < 16; w++) begin
          for (int l = 0; l < 4; l++) begin
            if (6'(w * 4 + l) == pos) begin
              msg_q[w][l] <= 8'h80;
            end else if (6'(w * 4 + l) > pos) begin
              msg_q[w][l] <= 8'h00;
            end
          end
        end
        if (pos < 6'd56) begin
          msg_q[14] <= bit_len[31:0];
          msg_q[15] <= bit_len[63:32];
        end
      end
      md5_pkg::OP_LEN: begin
        for (int w = 0; w < 14; w++) begin
          msg_q[w] <= '0;
        end
        msg_q[14] <= bit_len[31:0];
        msg_q[15] <= bit_len[63:32];
      end
      md5_pkg::OP_LOAD: begin
        a_q <= chain_q[0];
        b_q <= chain_q[1];
        c_q <= chain_q[2];
        d_q <= chain_q[3];
      end
      md5_pkg::OP_ROUND: begin
        a_q <= d_q;
        d_q <= c_q;
        c_q <= b_q;
        b_q <= b_d;
      end
      default: begin
      end
    endcase
    if (oload) begin
      odata_q <= chain_q[widx_q];
      oidx_q  <= widx_q;
      olast_q <= (widx_q == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      round_q  <= '0;
      widx_q   <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        chain_q[i] <= md5_pkg::CHAIN_INIT[i];
      end
    end else begin
      case (op_i)
        md5_pkg::OP_ACCEPT: begin
          if (accept_i && !req_type_i) begin
            count_q <= count_q + md5_pkg::COUNT_W'(1);
          end
        end
        md5_pkg::OP_LOAD: round_q <= '0;
        md5_pkg::OP_ROUND: round_q <= round_q + 6'd1;
        md5_pkg::OP_ADD: begin
          chain_q[0] <= chain_q[0] + a_q;
          chain_q[1] <= chain_q[1] + b_q;
          chain_q[2] <= chain_q[2] + c_q;
          chain_q[3] <= chain_q[3] + d_q;
        end
        md5_pkg::OP_INIT: begin
          count_q <= '0;
          for (int i = 0; i < 4; i++) begin
            chain_q[i] <= md5_pkg::CHAIN_INIT[i];
          end
        end
        default: begin
        end
      endcase
      if (oload) begin
        widx_q   <= widx_q + 2'd1;
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o   = ovalid_q;
  assign digest_word_o = odata_q;
  assign word_index_o  = oidx_q;
  assign last_word_o   = olast_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == md5_pkg::OP_ADD) |-> (round_q == 6'd0))
    else $error("chaining add before all 64 rounds ran");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == md5_pkg::OP_INIT) |=> (count_q == '0) && (widx_q == 2'd0))
    else $error("counters not cleared after digest");

endmodule
`default_nettype wire
